// File: hdl/pvre_pkg.sv
// Package for the PIN verify engine: register map, status codes, reference block helpers.
package pvre_pkg;

    // Limits on the PIN and on the reference block
    localparam int MAX_PIN_CHARS   = 8;
    localparam int MAX_BLOCK_BYTES = 16;

    // Configuration register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_PIN_TEXT      = 3'd0;
    localparam logic [2:0] REG_PIN_LENGTH    = 3'd1;
    localparam logic [2:0] REG_STORED_LENGTH = 3'd2;
    localparam logic [2:0] REG_PIN_ENCODING  = 3'd3;
    localparam logic [2:0] REG_PAD_CHAR      = 3'd4;
    localparam logic [2:0] REG_MAX_TRIES     = 3'd5;
    localparam logic [2:0] REG_PIN_REFERENCE = 3'd6;

    // Reset values of the registers and of the try counter
    localparam logic [63:0] RST_PIN_TEXT      = 64'h0;
    localparam logic [3:0]  RST_PIN_LENGTH    = 4'd4;
    localparam logic [4:0]  RST_STORED_LENGTH = 5'd8;
    localparam logic [1:0]  RST_PIN_ENCODING  = 2'd0;
    localparam logic [7:0]  RST_PAD_CHAR      = 8'hFF;
    localparam logic [3:0]  RST_MAX_TRIES     = 4'd3;
    localparam logic [7:0]  RST_PIN_REFERENCE = 8'd1;

    // PIN encodings
    localparam logic [1:0] ENC_ASCII      = 2'd0;
    localparam logic [1:0] ENC_BCD        = 2'd1;
    localparam logic [1:0] ENC_BCD_PREFIX = 2'd2;
    localparam logic [1:0] ENC_NONE       = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_P1P2  = 3'd1;
    localparam logic [2:0] ST_NO_REF    = 3'd2;
    localparam logic [2:0] ST_BLOCKED   = 3'd3;
    localparam logic [2:0] ST_WRONG_PIN = 3'd4;

    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] LEN_PREFIX  = 8'h20;

    typedef struct packed {
        logic [63:0] pin_text;
        logic [3:0]  pin_length;     // already clamped to MAX_PIN_CHARS
        logic [4:0]  stored_length;  // already clamped to MAX_BLOCK_BYTES
        logic [1:0]  pin_encoding;
        logic [7:0]  pad_char;
    } pin_cfg_t;

    // Pick one PIN character
    function automatic logic [7:0] pin_char(logic [63:0] text, logic [2:0] idx);
        return text[{idx, 3'b000} +: 8];
    endfunction

    // Length of the reference block, padding included
    function automatic logic [4:0] block_len(pin_cfg_t cfg);
        logic [4:0] content;
        logic [4:0] pairs;
        pairs = ({1'b0, cfg.pin_length} + 5'd1) >> 1;
        case (cfg.pin_encoding)
            ENC_ASCII:      content = {1'b0, cfg.pin_length};
            ENC_BCD:        content = pairs;
            ENC_BCD_PREFIX: content = pairs + 5'd1;
            default:        content = 5'd0;
        endcase
        return (content > cfg.stored_length) ? content : cfg.stored_length;
    endfunction

    // Byte of the reference block at position j
    function automatic logic [7:0] block_byte(pin_cfg_t cfg, logic [3:0] j);
        logic [3:0] k;
        logic [3:0] pairs;
        logic [2:0] ci;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] res;
        pairs = ({cfg.pin_length} + 4'd1) >> 1;
        k     = (cfg.pin_encoding == ENC_BCD_PREFIX) ? (j - 4'd1) : j;
        ci    = {k[1:0], 1'b0};
        hi    = pin_char(cfg.pin_text, ci) - DIGIT_ZERO;
        if (({1'b0, ci} + 4'd1) < cfg.pin_length)
            lo = pin_char(cfg.pin_text, ci + 3'd1) - DIGIT_ZERO;
        else
            lo = {4'h0, cfg.pad_char[3:0]};
        case (cfg.pin_encoding)
            ENC_ASCII:
                res = (j < cfg.pin_length) ? pin_char(cfg.pin_text, j[2:0]) : cfg.pad_char;
            ENC_BCD, ENC_BCD_PREFIX:
                if (cfg.pin_encoding == ENC_BCD_PREFIX && j == 4'd0)
                    res = LEN_PREFIX + {4'h0, cfg.pin_length};
                else if (k < pairs)
                    res = {hi[3:0], 4'h0} + lo;
                else
                    res = cfg.pad_char;
            default:
                res = cfg.pad_char;
        endcase
        return res;
    endfunction

endpackage

// File: hdl/pin_verify_retry_engine_unit.sv
// Top level of the PIN verify engine with try counter, stream ports and register port.
//
//  channel | direction | request                               | handshake
//  s_*     | in        | P1, P2, P3, one PIN byte, last marker | s_tvalid/s_tready
//  m_*     | out       | status, tries left, verified flag     | m_tvalid/m_tready
//  apb     | in        | register writes and reads             | psel/penable, pready tied high
//
// One request is taken per cycle while s_tready is high; its byte is checked against the
// reference block while it is offered, and the status of a last byte lands at the accepting
// edge in the output register, or in the skid stage if it is held; m_tvalid is high after it.
// The output register has a skid stage behind it, so requests keep flowing while one
// status waits; s_tready drops only when both are full.
// Async reset sets the try counter to three and all but the payload registers to defaults.
module pin_verify_retry_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // param_one[7:0], param_two[15:8], data_length[23:16],
                                   // data_byte[31:24]
    input  logic        s_tlast,   // last_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status[2:0], tries_left[6:3], verified[7]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [63:0] pin_text_reg;
    logic [3:0]  pin_length_reg;
    logic [4:0]  stored_length_reg;
    logic [1:0]  pin_encoding_reg;
    logic [7:0]  pad_char_reg;
    logic [3:0]  max_tries_reg;
    logic [7:0]  pin_reference_reg;

    // Engine state
    logic [3:0]  tries_reg,    tries_next;
    logic        verified_reg, verified_next;
    logic [7:0]  pos_reg,      pos_next;
    logic        mis_reg,      mis_next;

    // Output register and skid stage
    logic        out_valid_reg,  out_valid_next;
    logic [7:0]  out_data_reg,   out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [7:0]  skid_data_reg,  skid_data_next;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        acc;
    logic        push;
    logic        take;
    logic [7:0]  p1, p2, plen, pbyte;
    logic [2:0]  status;
    logic        match;
    logic        byte_bad;
    logic [4:0]  blen;
    logic [7:0]  ref_byte;
    pvre_pkg::pin_cfg_t cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[5:3];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_text_reg      <= pvre_pkg::RST_PIN_TEXT;
            pin_length_reg    <= pvre_pkg::RST_PIN_LENGTH;
            stored_length_reg <= pvre_pkg::RST_STORED_LENGTH;
            pin_encoding_reg  <= pvre_pkg::RST_PIN_ENCODING;
            pad_char_reg      <= pvre_pkg::RST_PAD_CHAR;
            max_tries_reg     <= pvre_pkg::RST_MAX_TRIES;
            pin_reference_reg <= pvre_pkg::RST_PIN_REFERENCE;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                pvre_pkg::REG_PIN_TEXT:      pin_text_reg      <= pwdata;
                pvre_pkg::REG_PIN_LENGTH:    pin_length_reg    <= pwdata[3:0];
                pvre_pkg::REG_STORED_LENGTH: stored_length_reg <= pwdata[4:0];
                pvre_pkg::REG_PIN_ENCODING:  pin_encoding_reg  <= pwdata[1:0];
                pvre_pkg::REG_PAD_CHAR:      pad_char_reg      <= pwdata[7:0];
                pvre_pkg::REG_MAX_TRIES:     max_tries_reg     <= pwdata[3:0];
                pvre_pkg::REG_PIN_REFERENCE: pin_reference_reg <= pwdata[7:0];
                default:                     ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (cfg_idx)
            pvre_pkg::REG_PIN_TEXT:      prdata = pin_text_reg;
            pvre_pkg::REG_PIN_LENGTH:    prdata = {60'h0, pin_length_reg};
            pvre_pkg::REG_STORED_LENGTH: prdata = {59'h0, stored_length_reg};
            pvre_pkg::REG_PIN_ENCODING:  prdata = {62'h0, pin_encoding_reg};
            pvre_pkg::REG_PAD_CHAR:      prdata = {56'h0, pad_char_reg};
            pvre_pkg::REG_MAX_TRIES:     prdata = {60'h0, max_tries_reg};
            pvre_pkg::REG_PIN_REFERENCE: prdata = {56'h0, pin_reference_reg};
            default:                     prdata = 64'h0;
        endcase
    end

    // Clamp lengths and build the reference byte at the current position
    always_comb
    begin
        cfg.pin_text      = pin_text_reg;
        cfg.pin_length    = (pin_length_reg > 4'(pvre_pkg::MAX_PIN_CHARS)) ?
                            4'(pvre_pkg::MAX_PIN_CHARS) : pin_length_reg;
        cfg.stored_length = (stored_length_reg > 5'(pvre_pkg::MAX_BLOCK_BYTES)) ?
                            5'(pvre_pkg::MAX_BLOCK_BYTES) : stored_length_reg;
        cfg.pin_encoding  = pin_encoding_reg;
        cfg.pad_char      = pad_char_reg;
    end

    assign blen     = pvre_pkg::block_len(cfg);
    assign ref_byte = pvre_pkg::block_byte(cfg, pos_reg[3:0]);

    assign p1    = s_tdata[7:0];
    assign p2    = s_tdata[15:8];
    assign plen  = s_tdata[23:16];
    assign pbyte = s_tdata[31:24];

    assign s_tready = !skid_valid_reg;
    assign acc      = s_tvalid & s_tready;
    assign push     = acc & s_tlast;
    assign take     = out_valid_reg & m_tready;

    // Compare the byte, advance the position, decide the status on the last byte
    always_comb
    begin
        byte_bad = (pin_encoding_reg == pvre_pkg::ENC_NONE) ||
                   (pos_reg >= {3'b000, blen}) || (ref_byte != pbyte);
        pos_next = pos_reg;
        mis_next = mis_reg;
        if (acc && plen != 8'd0)
        begin
            mis_next = mis_reg | byte_bad;
            if (pos_reg != 8'hFF)
                pos_next = pos_reg + 8'd1;
        end

        match = (pin_encoding_reg != pvre_pkg::ENC_NONE) && !mis_next &&
                (plen == {3'b000, blen}) && (pos_next == plen);

        tries_next    = tries_reg;
        verified_next = verified_reg;
        if (p1 != 8'd0)
            status = pvre_pkg::ST_BAD_P1P2;
        else if (p2 != pin_reference_reg)
            status = pvre_pkg::ST_NO_REF;
        else if (tries_reg == 4'd0)
            status = pvre_pkg::ST_BLOCKED;
        else if (match)
        begin
            status        = pvre_pkg::ST_OK;
            tries_next    = max_tries_reg;
            verified_next = 1'b1;
        end
        else
        begin
            status     = pvre_pkg::ST_WRONG_PIN;
            tries_next = tries_reg - 4'd1;
        end

        // Drop the per-command state after the last byte
        if (push)
        begin
            pos_next = 8'd0;
            mis_next = 1'b0;
        end
        else
        begin
            tries_next    = tries_reg;
            verified_next = verified_reg;
        end
    end

    // Steer the new status into the output register or the skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = {verified_next, tries_next, status};
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = {verified_next, tries_next, status};
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = {verified_next, tries_next, status};
        end
    end

    // Hold control and engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tries_reg      <= pvre_pkg::RST_MAX_TRIES;
            verified_reg   <= 1'b0;
            pos_reg        <= 8'd0;
            mis_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            tries_reg      <= tries_next;
            verified_reg   <= verified_next;
            pos_reg        <= pos_next;
            mis_reg        <= mis_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload of the output register and skid stage
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The skid stage only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // Input stalls only while a status is waiting
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no status waiting");

    // A last byte resets the per-command state
    a_new_command: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pos_reg == 8'd0) && !mis_reg)
        else $error("per-command state not cleared after last byte");

    // A good PIN leaves the flag set
    a_ok_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (push && status == pvre_pkg::ST_OK) |=> verified_reg)
        else $error("verified flag not set after good PIN");

    // Tries only change on a last byte
    a_tries_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !push |=> $stable(tries_reg))
        else $error("try counter changed outside a last byte");

endmodule
